// ===== rtl/core/olse_pkg.sv =====
// Shared types and constants for the ordered list stack engine.
`timescale 1ns / 1ps

package olse_pkg;

   localparam int KIND_W  = 4;
   localparam int POS_W   = 7;
   localparam int VAL_W   = 32;
   localparam int IDX_W   = 7;
   localparam int STAT_W  = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH   = 4'd0,
      KIND_POP    = 4'd1,
      KIND_TOP    = 4'd2,
      KIND_SIZE   = 4'd3,
      KIND_CLEAR  = 4'd4,
      KIND_INSERT = 4'd5,
      KIND_DELETE = 4'd6,
      KIND_GET    = 4'd7,
      KIND_LOCATE = 4'd8
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_BAD  = 2'd1,
      STATUS_FULL = 2'd2,
      STATUS_MISS = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RD,
      ST_CAP,
      ST_INS_CHK,
      ST_INS_WR,
      ST_DEL_CHK,
      ST_DEL_WR,
      ST_LOC_CHK,
      ST_LOC_CMP,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_LOAD_POS,
      PTR_LOAD_COUNT,
      PTR_LOAD_LAST,
      PTR_LOAD_ZERO,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   typedef enum logic [1:0] {
      RD_AT_PTR,
      RD_PTR_MINUS,
      RD_PTR_PLUS
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_VAL_AT_COUNT,
      WR_VAL_AT_PTR,
      WR_DATA_AT_PTR
   } wr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLEAR
   } cnt_op_type;

   typedef struct packed {
      logic       latch;
      ptr_op_type ptr_op;
      rd_sel_type rd_sel;
      wr_op_type  wr_op;
      cnt_op_type cnt_op;
      logic       cap_value;
      logic       set_found;
      logic       set_status;
      status_type status_code;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              full;
      logic              empty;
      logic              pos_gt_count;
      logic              pos_ge_count;
      logic              ptr_eq_pos;
      logic              ptr_at_end;
      logic              next_at_end;
      logic              match;
      logic              rsp_busy;
   } stat_type;

endpackage

// ===== rtl/core/olse_req_if.sv =====
// Request channel interface: valid, ready and the operation payload.
`timescale 1ns / 1ps

interface olse_req_if import olse_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [KIND_W-1:0]       kind;
   logic [POS_W-1:0]        position;
   logic signed [VAL_W-1:0] value_in;

   modport source (output valid, kind, position, value_in, input ready);
   modport sink   (input valid, kind, position, value_in, output ready);
endinterface

// ===== rtl/core/olse_rsp_if.sv =====
// Response channel interface: valid, ready and the result payload.
`timescale 1ns / 1ps

interface olse_rsp_if import olse_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] value_out;
   logic [IDX_W-1:0]        index_out;
   logic [STAT_W-1:0]       status;

   modport source (output valid, value_out, index_out, status, input ready);
   modport sink   (input valid, value_out, index_out, status, output ready);
endinterface

// ===== rtl/core/olse_ctrl.sv =====
// Controller state machine sequencing each list operation over the datapath.
`timescale 1ns / 1ps

module olse_ctrl import olse_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (stat.kind)
               KIND_PUSH: begin
                  if (stat.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_FULL;
                  end else begin
                     cmd.wr_op  = WR_VAL_AT_COUNT;
                     cmd.cnt_op = CNT_INC;
                  end
               end
               KIND_POP: begin
                  if (stat.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_BAD;
                  end else begin
                     cmd.ptr_op = PTR_LOAD_LAST;
                     cmd.cnt_op = CNT_DEC;
                     state_in   = ST_RD;
                  end
               end
               KIND_TOP: begin
                  if (stat.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_BAD;
                  end else begin
                     cmd.ptr_op = PTR_LOAD_LAST;
                     state_in   = ST_RD;
                  end
               end
               KIND_CLEAR: begin
                  cmd.cnt_op = CNT_CLEAR;
               end
               KIND_INSERT: begin
                  if (stat.pos_gt_count) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_BAD;
                  end else if (stat.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_FULL;
                  end else begin
                     cmd.ptr_op = PTR_LOAD_COUNT;
                     state_in   = ST_INS_CHK;
                  end
               end
               KIND_DELETE, KIND_GET: begin
                  if (stat.pos_ge_count) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_BAD;
                  end else begin
                     cmd.ptr_op = PTR_LOAD_POS;
                     state_in   = ST_RD;
                  end
               end
               KIND_LOCATE: begin
                  cmd.ptr_op = PTR_LOAD_ZERO;
                  state_in   = ST_LOC_CHK;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_RD: begin
            cmd.rd_sel = RD_AT_PTR;
            state_in   = ST_CAP;
         end
         ST_CAP: begin
            cmd.cap_value = 1'b1;
            state_in      = (stat.kind == KIND_DELETE) ? ST_DEL_CHK : ST_DONE;
         end
         ST_INS_CHK: begin
            if (stat.ptr_eq_pos) begin
               cmd.wr_op  = WR_VAL_AT_PTR;
               cmd.cnt_op = CNT_INC;
               state_in   = ST_DONE;
            end else begin
               cmd.rd_sel = RD_PTR_MINUS;
               state_in   = ST_INS_WR;
            end
         end
         ST_INS_WR: begin
            cmd.wr_op  = WR_DATA_AT_PTR;
            cmd.ptr_op = PTR_DEC;
            state_in   = ST_INS_CHK;
         end
         ST_DEL_CHK: begin
            if (stat.next_at_end) begin
               cmd.cnt_op = CNT_DEC;
               state_in   = ST_DONE;
            end else begin
               cmd.rd_sel = RD_PTR_PLUS;
               state_in   = ST_DEL_WR;
            end
         end
         ST_DEL_WR: begin
            cmd.wr_op  = WR_DATA_AT_PTR;
            cmd.ptr_op = PTR_INC;
            state_in   = ST_DEL_CHK;
         end
         ST_LOC_CHK: begin
            if (stat.ptr_at_end) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_MISS;
               state_in        = ST_DONE;
            end else begin
               cmd.rd_sel = RD_AT_PTR;
               state_in   = ST_LOC_CMP;
            end
         end
         ST_LOC_CMP: begin
            if (stat.match) begin
               cmd.set_found = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.ptr_op = PTR_INC;
               state_in   = ST_LOC_CHK;
            end
         end
         ST_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/olse_dpath.sv =====
// Datapath: list memory, count, position pointer and response register.
`timescale 1ns / 1ps

module olse_dpath import olse_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output stat_type                stat,
   input  logic [KIND_W-1:0]       req_kind,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_value_in,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] rsp_value_out,
   output logic [IDX_W-1:0]        rsp_index_out,
   output logic [STAT_W-1:0]       rsp_status
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   logic [VAL_W-1:0] mem [DEPTH];

   logic [KIND_W-1:0] kind_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [VAL_W-1:0]  val_ff;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic [CW-1:0]     ptr_ff;
   logic [CW-1:0]     ptr_in;
   logic [VAL_W-1:0]  rd_data_ff;
   logic [VAL_W-1:0]  value_res_ff;
   status_type        status_res_ff;
   logic              found_ff;
   logic              rsp_valid_ff;
   logic [VAL_W-1:0]  rsp_value_ff;
   logic [IDX_W-1:0]  rsp_index_ff;
   logic [STAT_W-1:0] rsp_status_ff;

   logic [CW-1:0]     ptr_plus;
   logic [CW-1:0]     ptr_minus;
   logic [CW-1:0]     rd_full;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [VAL_W-1:0]  wr_data;
   logic [CMPW-1:0]   pos_ext;
   logic [CMPW-1:0]   count_ext;
   logic [CMPW-1:0]   idx_ext;

   assign ptr_plus  = ptr_ff + CW'(1);
   assign ptr_minus = ptr_ff - CW'(1);
   assign pos_ext   = CMPW'(pos_ff);
   assign count_ext = CMPW'(count_ff);

   always_comb begin
      case (cmd.rd_sel)
         RD_PTR_MINUS: rd_full = ptr_minus;
         RD_PTR_PLUS:  rd_full = ptr_plus;
         default:      rd_full = ptr_ff;
      endcase
   end
   assign rd_addr = rd_full[AW-1:0];

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = ptr_ff[AW-1:0];
      wr_data = val_ff;
      case (cmd.wr_op)
         WR_VAL_AT_COUNT: wr_addr = count_ff[AW-1:0];
         WR_VAL_AT_PTR:   wr_data = val_ff;
         WR_DATA_AT_PTR:  wr_data = rd_data_ff;
         default:         wr_en   = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      case (cmd.cnt_op)
         CNT_INC:   count_in = count_ff + CW'(1);
         CNT_DEC:   count_in = count_ff - CW'(1);
         CNT_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase
   end

   always_comb begin
      case (cmd.ptr_op)
         PTR_LOAD_POS:   ptr_in = CW'(pos_ext);
         PTR_LOAD_COUNT: ptr_in = count_ff;
         PTR_LOAD_LAST:  ptr_in = count_ff - CW'(1);
         PTR_LOAD_ZERO:  ptr_in = '0;
         PTR_INC:        ptr_in = ptr_plus;
         PTR_DEC:        ptr_in = ptr_minus;
         default:        ptr_in = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.latch) begin
         kind_ff       <= req_kind;
         pos_ff        <= req_position;
         val_ff        <= req_value_in;
         value_res_ff  <= '0;
         status_res_ff <= STATUS_OK;
         found_ff      <= 1'b0;
      end else begin
         if (cmd.cap_value) begin
            value_res_ff <= rd_data_ff;
         end
         if (cmd.set_status) begin
            status_res_ff <= cmd.status_code;
         end
         if (cmd.set_found) begin
            found_ff <= 1'b1;
         end
      end
      if (cmd.emit) begin
         rsp_value_ff  <= value_res_ff;
         rsp_index_ff  <= idx_ext[IDX_W-1:0];
         rsp_status_ff <= status_res_ff;
      end
   end

   // locate hit reports the scan position, everything else the count
   assign idx_ext = found_ff ? CMPW'(ptr_ff) : count_ext;

   assign stat.kind         = kind_ff;
   assign stat.full         = (count_ff == CW'(DEPTH));
   assign stat.empty        = (count_ff == '0);
   assign stat.pos_gt_count = (pos_ext > count_ext);
   assign stat.pos_ge_count = (pos_ext >= count_ext);
   assign stat.ptr_eq_pos   = (CMPW'(ptr_ff) == pos_ext);
   assign stat.ptr_at_end   = (ptr_ff >= count_ff);
   assign stat.next_at_end  = (ptr_plus >= count_ff);
   assign stat.match        = (rd_data_ff == val_ff);
   assign stat.rsp_busy     = rsp_valid_ff && !rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_index_out = rsp_index_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ===== rtl/core/ordered_list_stack_engine.sv =====
// Top level of the ordered list stack engine: controller plus datapath.
//
// Holds an ordered list of up to DEPTH signed 32-bit values in a single
// memory with one write and one registered read port, and runs one request
// at a time. Push, size, clear, unused kinds and any refused request finish
// in the execute state; pop, top and get first read one entry. Insert at p
// shifts the entries from p to the end up by one, delete at p shifts those
// after p down by one, and locate scans from entry 0 to a hit or the end;
// shifts and scans move one entry at a time through the memory port. A
// finished response waits in an output register, so the next request is
// taken while the previous response is still pending.
`timescale 1ns / 1ps

module ordered_list_stack_engine import olse_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   olse_req_if.sink  req_chan,
   olse_rsp_if.source rsp_chan
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   olse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   olse_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_kind      (req_chan.kind),
      .req_position  (req_chan.position),
      .req_value_in  (req_chan.value_in),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_value_out (rsp_chan.value_out),
      .rsp_index_out (rsp_chan.index_out),
      .rsp_status    (rsp_chan.status)
   );

   assign req_chan.ready = req_ready;

endmodule
